// ===== hdl/ycr_pkg.sv =====
package ycr_pkg;

	// sample and fixed point widths
	localparam int unsigned SAMPLE_W      = 16;
	localparam int unsigned FRACTION_BITS = 16;
	localparam int unsigned COEF_W        = 16;
	localparam int unsigned COEF_SHIFT    = 14;
	localparam int unsigned OUT_W         = 8;
	localparam int unsigned DEPTH_W       = 5;
	localparam int unsigned CFG_IDX_W     = 4;
	localparam int unsigned CFG_DATA_W    = 16;

	// pipeline split
	localparam int unsigned LANE_STAGES = 6;
	localparam int unsigned MTX_STAGES  = 2;
	localparam int unsigned PIPE_STAGES = LANE_STAGES + MTX_STAGES + 1;

	// divider widths: studio numerator, normalize numerator, reciprocals
	localparam int unsigned STU_W = 2 * SAMPLE_W;
	localparam int unsigned NRM_W = SAMPLE_W + FRACTION_BITS;
	localparam int unsigned KS_W  = STU_W + 1;
	localparam int unsigned KN_W  = NRM_W + 1;
	localparam int unsigned QS_W  = SAMPLE_W + 1;
	localparam int unsigned N_W   = FRACTION_BITS + 1;

	// matrix widths
	localparam int unsigned C_W  = N_W + 1;
	localparam int unsigned P_W  = COEF_W + 1 + C_W;
	localparam int unsigned CH_W = P_W + 2;

	typedef logic [PIPE_STAGES-1:0] stage_en_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] luma;
		logic [SAMPLE_W-1:0] chroma_blue;
		logic [SAMPLE_W-1:0] chroma_red;
	} pix_in_t;

	typedef struct packed {
		logic [OUT_W-1:0] red;
		logic [OUT_W-1:0] green;
		logic [OUT_W-1:0] blue;
	} pix_out_t;

	typedef struct packed {
		logic [DEPTH_W-1:0] sample_depth;
		logic               studio_range;
		logic               identity_mode;
		logic               monochrome;
		logic [COEF_W-1:0]  red_from_cr;
		logic [COEF_W-1:0]  blue_from_cb;
		logic [COEF_W-1:0]  green_from_cr;
		logic [COEF_W-1:0]  green_from_cb;
	} cfg_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SAMPLE_DEPTH  = 4'd0,
		REG_STUDIO_RANGE  = 4'd1,
		REG_IDENTITY_MODE = 4'd2,
		REG_MONOCHROME    = 4'd3,
		REG_RED_FROM_CR   = 4'd4,
		REG_BLUE_FROM_CB  = 4'd5,
		REG_GREEN_FROM_CR = 4'd6,
		REG_GREEN_FROM_CB = 4'd7
	} cfg_reg_t;

	localparam cfg_t CFG_RESET = '{
		sample_depth:  5'd8,
		studio_range:  1'b0,
		identity_mode: 1'b0,
		monochrome:    1'b0,
		red_from_cr:   16'd25802,
		blue_from_cb:  16'd30402,
		green_from_cr: 16'd7669,
		green_from_cb: 16'd3068
	};

	typedef enum logic [1:0] {
		DEPTH_8,
		DEPTH_10,
		DEPTH_12,
		DEPTH_16
	} depth_sel_t;

	localparam int unsigned DEPTH_BITS [4] = '{8, 10, 12, 16};

	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX [4] = '{
		SAMPLE_W'(255), SAMPLE_W'(1023), SAMPLE_W'(4095), SAMPLE_W'(65535)
	};

	// studio limits, indexed by {depth, chroma}
	localparam int unsigned STU_LO [8] = '{16, 16, 64, 64, 256, 256, 1024, 1024};
	localparam int unsigned STU_DEN [8] = '{219, 224, 876, 896, 3504, 3584, 59136, 60416};

	// exact reciprocals: floor(n / d) = (n * K) >> (width + depth bits)
	localparam logic [KS_W-1:0] STU_RECIP [8] = '{
		KS_W'(((64'd1 << (STU_W + DEPTH_BITS[0])) + 64'(STU_DEN[0]) - 64'd1) / 64'(STU_DEN[0])),
		KS_W'(((64'd1 << (STU_W + DEPTH_BITS[0])) + 64'(STU_DEN[1]) - 64'd1) / 64'(STU_DEN[1])),
		KS_W'(((64'd1 << (STU_W + DEPTH_BITS[1])) + 64'(STU_DEN[2]) - 64'd1) / 64'(STU_DEN[2])),
		KS_W'(((64'd1 << (STU_W + DEPTH_BITS[1])) + 64'(STU_DEN[3]) - 64'd1) / 64'(STU_DEN[3])),
		KS_W'(((64'd1 << (STU_W + DEPTH_BITS[2])) + 64'(STU_DEN[4]) - 64'd1) / 64'(STU_DEN[4])),
		KS_W'(((64'd1 << (STU_W + DEPTH_BITS[2])) + 64'(STU_DEN[5]) - 64'd1) / 64'(STU_DEN[5])),
		KS_W'(((64'd1 << (STU_W + DEPTH_BITS[3])) + 64'(STU_DEN[6]) - 64'd1) / 64'(STU_DEN[6])),
		KS_W'(((64'd1 << (STU_W + DEPTH_BITS[3])) + 64'(STU_DEN[7]) - 64'd1) / 64'(STU_DEN[7]))
	};

	localparam logic [KN_W-1:0] NRM_RECIP [4] = '{
		KN_W'(((64'd1 << (NRM_W + DEPTH_BITS[0])) + 64'(SAMPLE_MAX[0]) - 64'd1)
			/ 64'(SAMPLE_MAX[0])),
		KN_W'(((64'd1 << (NRM_W + DEPTH_BITS[1])) + 64'(SAMPLE_MAX[1]) - 64'd1)
			/ 64'(SAMPLE_MAX[1])),
		KN_W'(((64'd1 << (NRM_W + DEPTH_BITS[2])) + 64'(SAMPLE_MAX[2]) - 64'd1)
			/ 64'(SAMPLE_MAX[2])),
		KN_W'(((64'd1 << (NRM_W + DEPTH_BITS[3])) + 64'(SAMPLE_MAX[3]) - 64'd1)
			/ 64'(SAMPLE_MAX[3]))
	};

	function automatic depth_sel_t depth_sel(logic [DEPTH_W-1:0] depth);
		depth_sel_t sel;
		case (depth)
			5'd10:   sel = DEPTH_10;
			5'd12:   sel = DEPTH_12;
			5'd16:   sel = DEPTH_16;
			default: sel = DEPTH_8;
		endcase
		return sel;
	endfunction

endpackage

// ===== hdl/ycbcr_to_rgb8_pixel_converter.sv =====
// ycbcr to 8-bit rgb pixel converter
//
// pixel input: pix_valid / pix_ready / pix_data (luma, chroma_blue, chroma_red),
//   a transaction moves one pixel; in identity mode the samples carry g, b, r
// pixel output: rgb_valid / rgb_ready / rgb_data (red, green, blue)
// config: cfg_valid / cfg_ready / cfg_index / cfg_data, always ready; write only
//   while no pixel is in flight; unknown indexes are dropped
//
// throughput: one pixel per clock unless a stall holds pix_ready low;
//   each of the nine stages holds one pixel and takes a new one in the
//   same cycle as it hands one on
// stall: with rgb_ready low the last stage holds its result; earlier stages
//   keep filling empty slots, so up to nine pixels are taken before pix_ready
//   drops; nothing is dropped or repeated
// reset: arst_n clears all pipeline valid bits and loads the default config
//   (8-bit samples, full range, ycbcr, bt.709 coefficients)
module ycbcr_to_rgb8_pixel_converter (
	input  logic                               clk,
	input  logic                               arst_n,

	input  logic                               pix_valid,
	output logic                               pix_ready,
	input  ycr_pkg::pix_in_t                   pix_data,

	output logic                               rgb_valid,
	input  logic                               rgb_ready,
	output ycr_pkg::pix_out_t                  rgb_data,

	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ycr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ycr_pkg::CFG_DATA_W-1:0]     cfg_data
);

	ycr_pkg::cfg_t                        cfg_q;
	ycr_pkg::stage_en_t                   en;
	logic                                 chroma_lim;
	logic [ycr_pkg::N_W-1:0]              luma_n, blue_n, red_n;
	logic signed [ycr_pkg::CH_W-1:0]      red_x, green_x, blue_x;

	// config registers, one write per transaction
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= ycr_pkg::CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ycr_pkg::REG_SAMPLE_DEPTH:  cfg_q.sample_depth  <= cfg_data[ycr_pkg::DEPTH_W-1:0];
				ycr_pkg::REG_STUDIO_RANGE:  cfg_q.studio_range  <= cfg_data[0];
				ycr_pkg::REG_IDENTITY_MODE: cfg_q.identity_mode <= cfg_data[0];
				ycr_pkg::REG_MONOCHROME:    cfg_q.monochrome    <= cfg_data[0];
				ycr_pkg::REG_RED_FROM_CR:   cfg_q.red_from_cr   <= cfg_data;
				ycr_pkg::REG_BLUE_FROM_CB:  cfg_q.blue_from_cb  <= cfg_data;
				ycr_pkg::REG_GREEN_FROM_CR: cfg_q.green_from_cr <= cfg_data;
				ycr_pkg::REG_GREEN_FROM_CB: cfg_q.green_from_cb <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// valid bits and per-stage load enables
	ycr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.rgb_valid (rgb_valid),
		.rgb_ready (rgb_ready),
		.en        (en)
	);

	// chroma lanes use the luma limits when the samples already hold g, b, r
	assign chroma_lim = !cfg_q.identity_mode;

	// three sample lanes: clamp, studio expansion, normalize (stages 1 to 6)
	ycr_lane u_lane_luma (
		.clk        (clk),
		.en         (en[ycr_pkg::LANE_STAGES-1:0]),
		.cfg        (cfg_q),
		.chroma_lim (1'b0),
		.sample     (pix_data.luma),
		.norm       (luma_n)
	);

	ycr_lane u_lane_blue (
		.clk        (clk),
		.en         (en[ycr_pkg::LANE_STAGES-1:0]),
		.cfg        (cfg_q),
		.chroma_lim (chroma_lim),
		.sample     (pix_data.chroma_blue),
		.norm       (blue_n)
	);

	ycr_lane u_lane_red (
		.clk        (clk),
		.en         (en[ycr_pkg::LANE_STAGES-1:0]),
		.cfg        (cfg_q),
		.chroma_lim (chroma_lim),
		.sample     (pix_data.chroma_red),
		.norm       (red_n)
	);

	// coefficient products and channel sums (stages 7 and 8)
	ycr_matrix u_matrix (
		.clk     (clk),
		.en      (en[ycr_pkg::LANE_STAGES +: ycr_pkg::MTX_STAGES]),
		.cfg     (cfg_q),
		.luma_n  (luma_n),
		.blue_n  (blue_n),
		.red_n   (red_n),
		.red_x   (red_x),
		.green_x (green_x),
		.blue_x  (blue_x)
	);

	// clamp and round to 8 bits, output register (stage 9)
	ycr_out u_out (
		.clk     (clk),
		.en      (en[ycr_pkg::PIPE_STAGES-1]),
		.red_x   (red_x),
		.green_x (green_x),
		.blue_x  (blue_x),
		.rgb     (rgb_data)
	);

endmodule

// ===== hdl/ycr_ctrl.sv =====
module ycr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pix_valid,
	output logic                 pix_ready,
	output logic                 rgb_valid,
	input  logic                 rgb_ready,
	output ycr_pkg::stage_en_t   en
);

	ycr_pkg::stage_en_t valid_q;
	ycr_pkg::stage_en_t en_c;
	ycr_pkg::stage_en_t feed;

	// a stage loads when empty or when the stage after it moves on
	always_comb begin
		en_c[ycr_pkg::PIPE_STAGES-1] = !valid_q[ycr_pkg::PIPE_STAGES-1] || rgb_ready;
		for (int k = ycr_pkg::PIPE_STAGES - 2; k >= 0; k--) begin
			en_c[k] = !valid_q[k] || en_c[k+1];
		end
	end

	assign feed = {valid_q[ycr_pkg::PIPE_STAGES-2:0], pix_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= (en_c & feed) | (~en_c & valid_q);
		end
	end

	assign en        = en_c;
	assign pix_ready = en_c[0];
	assign rgb_valid = valid_q[ycr_pkg::PIPE_STAGES-1];

endmodule

// ===== hdl/ycr_lane.sv =====
module ycr_lane (
	input  logic                                clk,
	input  logic [ycr_pkg::LANE_STAGES-1:0]     en,
	input  ycr_pkg::cfg_t                       cfg,
	input  logic                                chroma_lim,
	input  logic [ycr_pkg::SAMPLE_W-1:0]        sample,
	output logic [ycr_pkg::N_W-1:0]             norm
);

	ycr_pkg::depth_sel_t                           dsel;
	logic [2:0]                                    lim_idx;
	logic [ycr_pkg::SAMPLE_W-1:0]                  smax;
	logic [ycr_pkg::SAMPLE_W-1:0]                  lo;
	logic [ycr_pkg::SAMPLE_W-1:0]                  clamped;
	logic [ycr_pkg::STU_W-1:0]                     scaled;
	logic [ycr_pkg::STU_W+ycr_pkg::KS_W-1:0]       stu_prod;
	logic [ycr_pkg::QS_W-1:0]                      stu_q;
	logic [ycr_pkg::SAMPLE_W-1:0]                  full_val;
	logic [ycr_pkg::NRM_W-1:0]                     nrm_num;
	logic [ycr_pkg::NRM_W+ycr_pkg::KN_W-1:0]       nrm_prod;

	logic [ycr_pkg::SAMPLE_W-1:0]                  vc_s1, vc_s2, vc_s3;
	logic [ycr_pkg::SAMPLE_W-1:0]                  dl_s1;
	logic                                          below_s1, below_s2, below_s3;
	logic [ycr_pkg::STU_W-1:0]                     num_s2;
	logic [ycr_pkg::STU_W+ycr_pkg::KS_W-1:0]       prod_s3;
	logic [ycr_pkg::SAMPLE_W-1:0]                  vf_s4;
	logic [ycr_pkg::NRM_W+ycr_pkg::KN_W-1:0]       prod_s5;
	logic [ycr_pkg::N_W-1:0]                       norm_s6;

	assign dsel    = ycr_pkg::depth_sel(cfg.sample_depth);
	assign lim_idx = {dsel, chroma_lim};
	assign smax    = ycr_pkg::SAMPLE_MAX[dsel];
	assign lo      = ycr_pkg::SAMPLE_W'(ycr_pkg::STU_LO[lim_idx]);

	// clamp to depth, offset from black
	assign clamped = (sample > smax) ? smax : sample;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			vc_s1    <= clamped;
			dl_s1    <= clamped - lo;
			below_s1 <= clamped < lo;
		end
	end

	// studio numerator: (v - lo) * full + den / 2
	assign scaled = dl_s1 * smax;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			num_s2   <= scaled + ycr_pkg::STU_W'(ycr_pkg::STU_DEN[lim_idx] >> 1);
			vc_s2    <= vc_s1;
			below_s2 <= below_s1;
		end
	end

	assign stu_prod = num_s2 * ycr_pkg::STU_RECIP[lim_idx];

	always_ff @(posedge clk) begin
		if (en[2]) begin
			prod_s3  <= stu_prod;
			vc_s3    <= vc_s2;
			below_s3 <= below_s2;
		end
	end

	assign stu_q = prod_s3[ycr_pkg::STU_W + ycr_pkg::DEPTH_BITS[dsel] +: ycr_pkg::QS_W];

	always_comb begin
		priority if (!cfg.studio_range) begin
			full_val = vc_s3;
		end else if (below_s3) begin
			full_val = '0;
		end else if (stu_q > ycr_pkg::QS_W'(smax)) begin
			full_val = smax;
		end else begin
			full_val = stu_q[ycr_pkg::SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			vf_s4 <= full_val;
		end
	end

	// normalize: (v * 2^F + max / 2) / max
	assign nrm_num  = {vf_s4, ycr_pkg::FRACTION_BITS'(0)} + ycr_pkg::NRM_W'(smax >> 1);
	assign nrm_prod = nrm_num * ycr_pkg::NRM_RECIP[dsel];

	always_ff @(posedge clk) begin
		if (en[4]) begin
			prod_s5 <= nrm_prod;
		end
	end

	always_ff @(posedge clk) begin
		if (en[5]) begin
			norm_s6 <= prod_s5[ycr_pkg::NRM_W + ycr_pkg::DEPTH_BITS[dsel] +: ycr_pkg::N_W];
		end
	end

	assign norm = norm_s6;

endmodule

// ===== hdl/ycr_matrix.sv =====
module ycr_matrix (
	input  logic                                  clk,
	input  logic [ycr_pkg::MTX_STAGES-1:0]        en,
	input  ycr_pkg::cfg_t                         cfg,
	input  logic [ycr_pkg::N_W-1:0]               luma_n,
	input  logic [ycr_pkg::N_W-1:0]               blue_n,
	input  logic [ycr_pkg::N_W-1:0]               red_n,
	output logic signed [ycr_pkg::CH_W-1:0]       red_x,
	output logic signed [ycr_pkg::CH_W-1:0]       green_x,
	output logic signed [ycr_pkg::CH_W-1:0]       blue_x
);

	localparam logic signed [ycr_pkg::C_W-1:0] HALF =
		ycr_pkg::C_W'(1 << (ycr_pkg::FRACTION_BITS - 1));
	localparam logic signed [ycr_pkg::P_W:0] RND =
		(ycr_pkg::P_W + 1)'(1 << (ycr_pkg::COEF_SHIFT - 1));

	logic signed [ycr_pkg::C_W-1:0]   cb_c, cr_c;
	logic signed [ycr_pkg::P_W-1:0]   pr, pb, pgr, pgb;
	logic signed [ycr_pkg::P_W-1:0]   pr_s7, pb_s7, pgr_s7, pgb_s7;
	logic [ycr_pkg::N_W-1:0]          y_s7, b_s7, r_s7;
	logic signed [ycr_pkg::P_W:0]     pr_ext, pb_ext, pg_sum;
	logic signed [ycr_pkg::P_W:0]     rr, rb, rg;
	logic signed [ycr_pkg::CH_W-1:0]  y_ext, b_ext, r_ext;
	logic signed [ycr_pkg::CH_W-1:0]  red_c, green_c, blue_c;
	logic signed [ycr_pkg::CH_W-1:0]  red_s8, green_s8, blue_s8;

	// centre chroma
	assign cb_c = $signed({1'b0, blue_n}) - HALF;
	assign cr_c = $signed({1'b0, red_n}) - HALF;

	assign pr  = $signed({1'b0, cfg.red_from_cr}) * cr_c;
	assign pb  = $signed({1'b0, cfg.blue_from_cb}) * cb_c;
	assign pgr = $signed({1'b0, cfg.green_from_cr}) * cr_c;
	assign pgb = $signed({1'b0, cfg.green_from_cb}) * cb_c;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			pr_s7  <= pr;
			pb_s7  <= pb;
			pgr_s7 <= pgr;
			pgb_s7 <= pgb;
			y_s7   <= luma_n;
			b_s7   <= blue_n;
			r_s7   <= red_n;
		end
	end

	// round half up on the products of the Q2.14 coefficients
	assign pr_ext = pr_s7;
	assign pb_ext = pb_s7;
	assign pg_sum = pgr_s7 + pgb_s7;

	assign rr = (pr_ext + RND) >>> ycr_pkg::COEF_SHIFT;
	assign rb = (pb_ext + RND) >>> ycr_pkg::COEF_SHIFT;
	assign rg = (pg_sum + RND) >>> ycr_pkg::COEF_SHIFT;

	assign y_ext = $signed({1'b0, y_s7});
	assign b_ext = $signed({1'b0, b_s7});
	assign r_ext = $signed({1'b0, r_s7});

	always_comb begin
		priority if (cfg.monochrome) begin
			red_c   = y_ext;
			green_c = y_ext;
			blue_c  = y_ext;
		end else if (cfg.identity_mode) begin
			red_c   = r_ext;
			green_c = y_ext;
			blue_c  = b_ext;
		end else begin
			red_c   = y_ext + rr;
			green_c = y_ext - rg;
			blue_c  = y_ext + rb;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			red_s8   <= red_c;
			green_s8 <= green_c;
			blue_s8  <= blue_c;
		end
	end

	assign red_x   = red_s8;
	assign green_x = green_s8;
	assign blue_x  = blue_s8;

endmodule

// ===== hdl/ycr_out.sv =====
module ycr_out (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [ycr_pkg::CH_W-1:0]   red_x,
	input  logic signed [ycr_pkg::CH_W-1:0]   green_x,
	input  logic signed [ycr_pkg::CH_W-1:0]   blue_x,
	output ycr_pkg::pix_out_t                 rgb
);

	localparam logic signed [ycr_pkg::CH_W-1:0] ONE =
		ycr_pkg::CH_W'(1 << ycr_pkg::FRACTION_BITS);
	localparam logic [ycr_pkg::N_W+ycr_pkg::OUT_W-1:0] HALF_LSB =
		(ycr_pkg::N_W + ycr_pkg::OUT_W)'(1 << (ycr_pkg::FRACTION_BITS - 1));

	// clamp to 0..1, then scale by 255 with rounding
	function automatic logic [ycr_pkg::OUT_W-1:0] to8(logic signed [ycr_pkg::CH_W-1:0] x);
		logic [ycr_pkg::N_W-1:0]               c;
		logic [ycr_pkg::N_W+ycr_pkg::OUT_W-1:0] s;
		priority if (x[ycr_pkg::CH_W-1]) begin
			c = '0;
		end else if (x > ONE) begin
			c = ONE[ycr_pkg::N_W-1:0];
		end else begin
			c = x[ycr_pkg::N_W-1:0];
		end
		s = {c, ycr_pkg::OUT_W'(0)} - (ycr_pkg::N_W + ycr_pkg::OUT_W)'(c) + HALF_LSB;
		return s[ycr_pkg::FRACTION_BITS +: ycr_pkg::OUT_W];
	endfunction

	ycr_pkg::pix_out_t rgb_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			rgb_s9.red   <= to8(red_x);
			rgb_s9.green <= to8(green_x);
			rgb_s9.blue  <= to8(blue_x);
		end
	end

	assign rgb = rgb_s9;

endmodule

// ===== tb/sv/ycbcr_to_rgb8_pixel_converter_tb.sv =====
module ycbcr_to_rgb8_pixel_converter_tb;

	import ycr_pkg::*;

	// run shape
	localparam int HOLD_CYCLES     = 80;    // long output stall, counted by the receiver
	localparam int STALL_LIMIT     = 2000;  // cycles with no transaction before giving up
	localparam int PHASES          = 10;    // random register settings
	localparam int ITEMS_PER_PHASE = 100;

	// studio range limits for one sample depth
	typedef struct {
		int unsigned lo;
		int unsigned hi;
		int unsigned full;
	} limits_t;

	// one row of the directed table
	typedef struct {
		cfg_t     setting;
		pix_in_t  pix;
		bit       typed;    // expected colour typed in below, else predicted
		pix_out_t want;
	} vector_t;

	// receiver stall patterns
	typedef enum {
		READY_ALWAYS,
		READY_COIN,
		READY_MOSTLY,
		READY_BURSTY
	} ready_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  pix_valid;
	logic                  pix_ready;
	pix_in_t               pix_data;
	logic                  rgb_valid;
	logic                  rgb_ready;
	pix_out_t              rgb_data;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// predictor copy of the registers and the colours still owed by the block
	cfg_t     cfg_now;
	pix_out_t rgb_expected[$];
	vector_t  directed_rows[$];

	int mismatches       = 0;
	int pixels_sent      = 0;
	int pixels_checked   = 0;
	int settings_applied = 0;
	int hold_requests    = 0;
	int quiet_cycles     = 0;

	ycbcr_to_rgb8_pixel_converter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix_data  (pix_data),
		.rgb_valid (rgb_valid),
		.rgb_ready (rgb_ready),
		.rgb_data  (rgb_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------
	// colour predictor
	// ---------------------------------------------------------------

	// depths other than 10, 12 and 16 fall back to 8 bits
	function automatic int unsigned eff_bits(logic [DEPTH_W-1:0] depth);
		int unsigned bits;
		case (depth)
			5'd10:   bits = 10;
			5'd12:   bits = 12;
			5'd16:   bits = 16;
			default: bits = 8;
		endcase
		return bits;
	endfunction

	// black, white (or chroma extreme) and full scale for studio expansion
	function automatic limits_t studio_limits(int unsigned bits, bit chroma_lim);
		limits_t lim;
		case (bits)
			10:      lim = '{64, chroma_lim ? 960 : 940, 1023};
			12:      lim = '{256, chroma_lim ? 3840 : 3760, 4095};
			16:      lim = '{1024, chroma_lim ? 61440 : 60160, 65535};
			default: lim = '{16, chroma_lim ? 240 : 235, 255};
		endcase
		return lim;
	endfunction

	// clamp to depth, optional studio expansion, then scale to a Q1.16 fraction
	function automatic longint level(logic [SAMPLE_W-1:0] s, int unsigned bits,
			bit chroma_lim, bit studio);
		limits_t lim;
		longint unsigned top, v, den, q;
		top = (64'd1 << bits) - 1;
		v = s;
		if (v > top)
			v = top;
		if (studio) begin
			lim = studio_limits(bits, chroma_lim);
			den = lim.hi - lim.lo;
			if (v < lim.lo) begin
				v = 0;
			end else begin
				q = ((v - lim.lo) * lim.full + den / 2) / den;
				v = (q > lim.full) ? lim.full : q;
			end
		end
		return longint'(((v << FRACTION_BITS) + top / 2) / top);
	endfunction

	// product of a q2.14 coefficient back to q1.16, rounding half up, also for negatives
	function automatic longint round14(longint x);
		return (x + (longint'(1) << (COEF_SHIFT - 1))) >>> COEF_SHIFT;
	endfunction

	// clamp to 0..1 and round to 8 bits
	function automatic logic [OUT_W-1:0] to_byte(longint x);
		longint one;
		one = longint'(1) << FRACTION_BITS;
		if (x < 0)
			x = 0;
		if (x > one)
			x = one;
		return OUT_W'((x * 255 + (one >> 1)) >> FRACTION_BITS);
	endfunction

	function automatic pix_out_t predict_rgb(pix_in_t p, cfg_t c);
		int unsigned bits;
		longint half, y, cb, cr, r, g, b;
		pix_out_t o;
		bits = eff_bits(c.sample_depth);
		half = longint'(1) << (FRACTION_BITS - 1);
		y = level(p.luma, bits, 1'b0, c.studio_range);
		if (c.monochrome) begin
			// gray from luma, chroma ignored even in identity mode
			r = y;
			g = y;
			b = y;
		end else if (c.identity_mode) begin
			// samples already hold g, b, r and all use the luma limits
			g = y;
			b = level(p.chroma_blue, bits, 1'b0, c.studio_range);
			r = level(p.chroma_red, bits, 1'b0, c.studio_range);
		end else begin
			cb = level(p.chroma_blue, bits, 1'b1, c.studio_range) - half;
			cr = level(p.chroma_red, bits, 1'b1, c.studio_range) - half;
			r = y + round14(longint'(c.red_from_cr) * cr);
			b = y + round14(longint'(c.blue_from_cb) * cb);
			g = y - round14(longint'(c.green_from_cr) * cr + longint'(c.green_from_cb) * cb);
		end
		o.red   = to_byte(r);
		o.green = to_byte(g);
		o.blue  = to_byte(b);
		return o;
	endfunction

	// ---------------------------------------------------------------
	// stimulus generation
	// ---------------------------------------------------------------

	function automatic pix_in_t noise_pixel();
		pix_in_t p;
		p.luma        = SAMPLE_W'($urandom);
		p.chroma_blue = SAMPLE_W'($urandom);
		p.chroma_red  = SAMPLE_W'($urandom);
		return p;
	endfunction

	// mostly in range for the depth, with weight on the ends and the studio limits
	function automatic logic [SAMPLE_W-1:0] rand_sample(int unsigned bits, bit chroma_lim);
		limits_t lim;
		int unsigned top;
		logic [SAMPLE_W-1:0] s;
		lim = studio_limits(bits, chroma_lim);
		top = (1 << bits) - 1;
		case ($urandom_range(0, 9))
			0:       s = SAMPLE_W'($urandom);
			1:       s = '0;
			2:       s = SAMPLE_W'(top);
			3:       s = SAMPLE_W'(lim.lo - 1 + $urandom_range(0, 2));
			4:       s = SAMPLE_W'(lim.hi - 1 + $urandom_range(0, 2));
			default: s = SAMPLE_W'($urandom_range(0, top));
		endcase
		return s;
	endfunction

	function automatic pix_in_t rand_pixel(cfg_t c);
		int unsigned bits;
		pix_in_t p;
		bits = eff_bits(c.sample_depth);
		if ($urandom_range(0, 11) == 0)
			return noise_pixel();
		p.luma        = rand_sample(bits, 1'b0);
		p.chroma_blue = rand_sample(bits, !c.identity_mode);
		p.chroma_red  = rand_sample(bits, !c.identity_mode);
		return p;
	endfunction

	// first four phases walk the listed depths, later ones may pick odd depths
	function automatic cfg_t rand_setting(int phase);
		cfg_t c;
		c = CFG_RESET;
		if (phase < 4)
			c.sample_depth = DEPTH_W'(DEPTH_BITS[phase]);
		else if ($urandom_range(0, 3) == 0)
			c.sample_depth = DEPTH_W'($urandom);
		else
			c.sample_depth = DEPTH_W'(DEPTH_BITS[$urandom_range(0, 3)]);
		c.studio_range  = 1'($urandom_range(0, 1));
		c.identity_mode = ($urandom_range(0, 3) == 0);
		c.monochrome    = ($urandom_range(0, 4) == 0);
		case ($urandom_range(0, 3))
			0: ;  // stock coefficients
			1: begin
				c.red_from_cr   = COEF_W'($urandom);
				c.blue_from_cb  = COEF_W'($urandom);
				c.green_from_cr = COEF_W'($urandom);
				c.green_from_cb = COEF_W'($urandom);
			end
			2: begin
				c.red_from_cr   = $urandom_range(0, 1) ? '1 : '0;
				c.blue_from_cb  = $urandom_range(0, 1) ? '1 : '0;
				c.green_from_cr = $urandom_range(0, 1) ? '1 : '0;
				c.green_from_cb = $urandom_range(0, 1) ? '1 : '0;
			end
			default: begin
				// neighborhood of the stock coefficients
				c.red_from_cr   = CFG_RESET.red_from_cr + COEF_W'($urandom_range(0, 4000)) - 2000;
				c.blue_from_cb  = CFG_RESET.blue_from_cb + COEF_W'($urandom_range(0, 4000)) - 2000;
				c.green_from_cr = CFG_RESET.green_from_cr + COEF_W'($urandom_range(0, 2000)) - 1000;
				c.green_from_cb = CFG_RESET.green_from_cb + COEF_W'($urandom_range(0, 2000)) - 1000;
			end
		endcase
		return c;
	endfunction

	// ---------------------------------------------------------------
	// drivers: everything changes on the falling edge
	// ---------------------------------------------------------------

	// offer one pixel and hold it until the transaction happens
	task automatic send_pixel(input pix_in_t p, input pix_out_t want);
		@(negedge clk);
		pix_valid <= 1'b1;
		pix_data  <= p;
		do @(posedge clk); while (!pix_ready);
		rgb_expected.push_back(want);
		pixels_sent++;
	endtask

	// sender gap, with junk on the data lines
	task automatic idle_pixels(input int n);
		repeat (n) begin
			@(negedge clk);
			pix_valid <= 1'b0;
			pix_data  <= noise_pixel();
		end
	endtask

	// stop offering and wait until every owed colour has come out
	task automatic drain_results();
		@(negedge clk);
		pix_valid <= 1'b0;
		while (rgb_expected.size() != 0)
			@(posedge clk);
	endtask

	// one register write; the predictor keeps only the bits the register holds
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_SAMPLE_DEPTH:  cfg_now.sample_depth  = data[DEPTH_W-1:0];
			REG_STUDIO_RANGE:  cfg_now.studio_range  = data[0];
			REG_IDENTITY_MODE: cfg_now.identity_mode = data[0];
			REG_MONOCHROME:    cfg_now.monochrome    = data[0];
			REG_RED_FROM_CR:   cfg_now.red_from_cr   = data;
			REG_BLUE_FROM_CB:  cfg_now.blue_from_cb  = data;
			REG_GREEN_FROM_CR: cfg_now.green_from_cr = data;
			REG_GREEN_FROM_CB: cfg_now.green_from_cb = data;
			default: ;  // unknown index, dropped by the block
		endcase
	endtask

	// idle the pipe, write all eight registers, then a write to an unused index
	task automatic program_cfg(input cfg_t c);
		cfg_reg_t r;
		logic [CFG_DATA_W-1:0] data;
		drain_results();
		for (int i = 0; i <= int'(REG_GREEN_FROM_CB); i++) begin
			r = cfg_reg_t'(i);
			data = CFG_DATA_W'($urandom);  // junk above narrow fields
			case (r)
				REG_SAMPLE_DEPTH:  data[DEPTH_W-1:0] = c.sample_depth;
				REG_STUDIO_RANGE:  data[0] = c.studio_range;
				REG_IDENTITY_MODE: data[0] = c.identity_mode;
				REG_MONOCHROME:    data[0] = c.monochrome;
				REG_RED_FROM_CR:   data = c.red_from_cr;
				REG_BLUE_FROM_CB:  data = c.blue_from_cb;
				REG_GREEN_FROM_CR: data = c.green_from_cr;
				REG_GREEN_FROM_CB: data = c.green_from_cb;
				default: ;
			endcase
			write_reg(r, data);
		end
		write_reg(CFG_IDX_W'($urandom_range(8, 15)), CFG_DATA_W'($urandom));
		@(negedge clk);
		cfg_valid <= 1'b0;
		settings_applied++;
	endtask

	task automatic add_vector(input cfg_t s, input logic [SAMPLE_W-1:0] y, cb, cr,
			input bit typed, input logic [OUT_W-1:0] r, g, b);
		vector_t v;
		v.setting = s;
		v.pix     = '{luma: y, chroma_blue: cb, chroma_red: cr};
		v.typed   = typed;
		v.want    = '{red: r, green: g, blue: b};
		directed_rows.push_back(v);
	endtask

	// ---------------------------------------------------------------
	// receiver: own stall pattern, plus a long hold-off on request
	// ---------------------------------------------------------------

	initial begin : receiver
		int hold_left, mode_left, period, holds_started;
		ready_mode_t mode;
		hold_left     = 0;
		mode_left     = 0;
		period        = 1;
		holds_started = 0;
		mode          = READY_ALWAYS;
		rgb_ready     = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_started != hold_requests) begin
				holds_started = hold_requests;
				hold_left     = HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				mode      = ready_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(16, 96);
				period    = $urandom_range(1, 6);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				rgb_ready <= 1'b0;
			end else begin
				case (mode)
					READY_ALWAYS: rgb_ready <= 1'b1;
					READY_COIN:   rgb_ready <= 1'($urandom_range(0, 1));
					READY_MOSTLY: rgb_ready <= ($urandom_range(0, 9) != 0);
					default:      rgb_ready <= ((mode_left / period) % 2 == 0);
				endcase
			end
		end
	end

	// ---------------------------------------------------------------
	// checker: every output transaction against the oldest owed colour
	// ---------------------------------------------------------------

	task automatic compare_channel(input string name, input logic [OUT_W-1:0] want, got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : check_rgb
		pix_out_t want;
		if (rgb_valid && rgb_ready) begin
			if (rgb_expected.size() == 0) begin
				$display("%0t: unexpected colour, expected none, actual %h", $time, rgb_data);
				mismatches++;
			end else begin
				want = rgb_expected.pop_front();
				compare_channel("red", want.red, rgb_data.red);
				compare_channel("green", want.green, rgb_data.green);
				compare_channel("blue", want.blue, rgb_data.blue);
				pixels_checked++;
			end
		end
	end

	// watchdog: too long without any transaction means the block hung
	always @(posedge clk) begin
		if (!arst_n || (pix_valid && pix_ready) || (rgb_valid && rgb_ready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
			$display("FAILED: results differ");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ---------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------

	initial begin : main
		cfg_t s_mono, s_ident, s_studio, s_studio_mono, s_id10, s_wide12, s_zero16, s_odd9;
		pix_in_t pix;
		int sent_in_phase, burst;

		arst_n    = 1'b0;
		pix_valid = 1'b0;
		pix_data  = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		cfg_now   = CFG_RESET;

		// settings used by the directed table
		s_mono = CFG_RESET;
		s_mono.monochrome = 1'b1;
		s_ident = CFG_RESET;
		s_ident.identity_mode = 1'b1;
		s_studio = CFG_RESET;
		s_studio.studio_range = 1'b1;
		s_studio_mono = s_studio;
		s_studio_mono.monochrome = 1'b1;
		s_id10 = CFG_RESET;
		s_id10.sample_depth  = 5'd10;
		s_id10.studio_range  = 1'b1;
		s_id10.identity_mode = 1'b1;
		s_wide12 = CFG_RESET;
		s_wide12.sample_depth  = 5'd12;
		s_wide12.red_from_cr   = '1;
		s_wide12.blue_from_cb  = '1;
		s_wide12.green_from_cr = '1;
		s_wide12.green_from_cb = '1;
		s_zero16 = CFG_RESET;
		s_zero16.sample_depth  = 5'd16;
		s_zero16.studio_range  = 1'b1;
		s_zero16.red_from_cr   = '0;
		s_zero16.blue_from_cb  = '0;
		s_zero16.green_from_cr = '0;
		s_zero16.green_from_cb = '0;
		s_odd9 = CFG_RESET;
		s_odd9.sample_depth = 5'd9;  // unlisted depth, acts as 8 bits

		// default registers straight out of reset
		add_vector(CFG_RESET, 16'd0, 16'd0, 16'd0, 0, 0, 0, 0);
		add_vector(CFG_RESET, 16'd255, 16'd255, 16'd255, 0, 0, 0, 0);
		add_vector(CFG_RESET, 16'd128, 16'd128, 16'd128, 0, 0, 0, 0);
		add_vector(CFG_RESET, 16'hFFFF, 16'hFFFF, 16'h0000, 0, 0, 0, 0);
		add_vector(CFG_RESET, 16'h00FF, 16'h8000, 16'h0100, 0, 0, 0, 0);
		// gray from luma, chroma ignored, over-range luma clamps to white
		add_vector(s_mono, 16'd0, 16'hFFFF, 16'd0, 1, 0, 0, 0);
		add_vector(s_mono, 16'd255, 16'd0, 16'hFFFF, 1, 255, 255, 255);
		add_vector(s_mono, 16'hFFFF, 16'h1234, 16'h5678, 1, 255, 255, 255);
		// identity: luma is g, chroma blue is b, chroma red is r
		add_vector(s_ident, 16'd255, 16'd0, 16'd255, 1, 255, 255, 0);
		add_vector(s_ident, 16'd0, 16'd255, 16'd0, 1, 0, 0, 255);
		add_vector(s_ident, 16'hFFFF, 16'h1234, 16'h00AA, 0, 0, 0, 0);
		// studio range, including samples under black and over white
		add_vector(s_studio, 16'd16, 16'd16, 16'd240, 0, 0, 0, 0);
		add_vector(s_studio, 16'd235, 16'd240, 16'd16, 0, 0, 0, 0);
		add_vector(s_studio, 16'd5, 16'd0, 16'hFFFF, 0, 0, 0, 0);
		add_vector(s_studio_mono, 16'd10, 16'd99, 16'd99, 1, 0, 0, 0);
		add_vector(s_studio_mono, 16'd235, 16'd0, 16'd0, 1, 255, 255, 255);
		// 10-bit studio identity: chroma samples use the luma limits
		add_vector(s_id10, 16'd64, 16'd940, 16'd1023, 1, 255, 0, 255);
		add_vector(s_id10, 16'hFFFF, 16'd0, 16'd500, 0, 0, 0, 0);
		// 12-bit with every coefficient at its top
		add_vector(s_wide12, 16'd0, 16'd4095, 16'd0, 0, 0, 0, 0);
		add_vector(s_wide12, 16'd4095, 16'd0, 16'd4095, 0, 0, 0, 0);
		// 16-bit studio with zero coefficients: output follows luma alone
		add_vector(s_zero16, 16'hFFFF, 16'd0, 16'hFFFF, 1, 255, 255, 255);
		add_vector(s_zero16, 16'd1024, 16'hFFFF, 16'd0, 1, 0, 0, 0);
		add_vector(s_odd9, 16'd255, 16'd128, 16'd128, 0, 0, 0, 0);
		add_vector(s_odd9, 16'h0100, 16'h01FF, 16'd3, 0, 0, 0, 0);

		// reset once, released away from the rising edge
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table, reprogramming only when the row's setting changes
		foreach (directed_rows[i]) begin
			if (directed_rows[i].setting != cfg_now)
				program_cfg(directed_rows[i].setting);
			send_pixel(directed_rows[i].pix, directed_rows[i].typed ? directed_rows[i].want
				: predict_rgb(directed_rows[i].pix, cfg_now));
		end

		// random phases: new registers, then bursts of pixels with gaps
		for (int phase = 0; phase < PHASES; phase++) begin
			program_cfg(rand_setting(phase));
			sent_in_phase = 0;
			while (sent_in_phase < ITEMS_PER_PHASE) begin
				if (phase == 0 && sent_in_phase >= 30 && hold_requests == 0) begin
					// receiver holds off while pixels keep coming, so the pipe fills up
					hold_requests++;
					burst = 40;
				end else begin
					burst = $urandom_range(1, 24);
				end
				repeat (burst) begin
					pix = rand_pixel(cfg_now);
					send_pixel(pix, predict_rgb(pix, cfg_now));
				end
				sent_in_phase += burst;
				if ($urandom_range(0, 14) == 0)
					drain_results();
				else if ($urandom_range(0, 3) != 0)
					idle_pixels($urandom_range(1, 12));
			end
		end

		// let the last colours out, then a few more cycles to catch strays
		drain_results();
		repeat (2 * PIPE_STAGES) @(posedge clk);

		$display("%0d pixels checked under %0d register settings: depths 8, 10, 12, 16 and odd,",
			pixels_checked, settings_applied);
		$display("full and studio range, matrix, identity and monochrome, long output stall");
		if (mismatches == 0 && rgb_expected.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/ycr_pkg.sv
hdl/ycr_ctrl.sv
hdl/ycr_lane.sv
hdl/ycr_matrix.sv
hdl/ycr_out.sv
hdl/ycbcr_to_rgb8_pixel_converter.sv
tb/sv/ycbcr_to_rgb8_pixel_converter_tb.sv
